@@ src/linear_probe_hash_table_top_assert.svh @@
// assertion macros for the linear probe hash table
// expects clk and rst_n in the scope where a macro is used
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPHT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
// shared widths, codes and defaults for the linear probe hash table
// no dependencies
package lpht_pkg;

  localparam int KEY_W = 50;
  localparam int REC_W = 16;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  localparam int DEF_TABLE_SLOTS = 997;
  localparam int DEF_MAX_PROBES  = 996;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 2'd3;

endpackage

@@ src/linear_probe_hash_table_top.sv @@
// linear probe hash table: key and record memories, digit-folding home slot unit, probe sequencer
// depends on lpht_pkg and linear_probe_hash_table_top_assert.svh
`include "linear_probe_hash_table_top_assert.svh"

// Open-addressing hash table with linear probing. After reset the block is busy while
// it empties the key memory, one slot a cycle. A command is taken when start is high
// and busy is low; a zero key is answered in the next cycle. Any other command first
// works out the home slot (key mod TABLE_SLOTS) by folding: each cycle the key bits
// above the slot width are weighted by 2**SLOT_W mod TABLE_SLOTS and added to the low
// bits, until the value fits the slot width, and a final compare-subtract brings it
// below TABLE_SLOTS. Then it visits each slot in two states, S_READ for the registered
// memory read and S_CMP for the compare; a search or delete miss or a full table
// visits MAX_PROBES + 1 slots. The result appears for one cycle with out_valid, for a
// nonzero key in the cycle in which busy falls, and must be captured then: the
// receiver cannot stall the block.
module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int MAX_PROBES  = DEF_MAX_PROBES,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS),
  localparam int CNT_W      = $clog2(MAX_PROBES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [KEY_W-1:0]  in_phone_number,
  input  logic [REC_W-1:0]  in_record_handle,
  output logic              out_valid,
  output logic              out_found,
  output logic [SLOT_W-1:0] out_slot_index,
  output logic [REC_W-1:0]  out_record_out,
  output logic [ST_W-1:0]   out_status
);

  localparam logic [SLOT_W:0]   SLOTS_C    = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(MAX_PROBES);
  // weight of one slot-width digit, 2**SLOT_W mod TABLE_SLOTS
  localparam logic [KEY_W-1:0]  FOLD_C     = KEY_W'((1 << SLOT_W) - TABLE_SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MOD   = 5'b00100,
    S_READ  = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  shift_r, shift_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [REC_W-1:0]  out_rec_r, out_rec_nxt;
  logic [ST_W-1:0]   out_st_r, out_st_nxt;

  // memories and their registered read data
  logic [KEY_W-1:0] key_mem [TABLE_SLOTS];
  logic [REC_W-1:0] rec_mem [TABLE_SLOTS];
  logic [KEY_W-1:0] key_q;
  logic [REC_W-1:0] rec_q;

  logic             key_we;
  logic [KEY_W-1:0] key_wdata;
  logic             rec_we;

  // shared fold step, final compare-subtract and helpers
  logic [KEY_W-1:0]  fold_hi;
  logic [KEY_W-1:0]  fold_sum;
  logic              fold_done;
  logic [SLOT_W:0]   mod_t;
  logic [SLOT_W:0]   mod_diff;
  logic [SLOT_W-1:0] mod_step;
  logic [SLOT_W-1:0] pos_inc;
  logic              is_insert;
  logic [KEY_W-1:0]  target;
  logic              hit;

  // upper digits folded onto the low digit, never overflows KEY_W bits
  assign fold_hi   = shift_r >> SLOT_W;
  assign fold_sum  = fold_hi * FOLD_C + {{(KEY_W - SLOT_W){1'b0}}, shift_r[SLOT_W-1:0]};
  assign fold_done = (fold_hi == '0);

  assign mod_t    = {1'b0, shift_r[SLOT_W-1:0]};
  assign mod_diff = mod_t - SLOTS_C;
  assign mod_step = (mod_t >= SLOTS_C) ? mod_diff[SLOT_W-1:0] : mod_t[SLOT_W-1:0];
  assign pos_inc  = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;

  assign is_insert = (cmd_r == CMD_INSERT);
  assign target    = is_insert ? '0 : key_r;
  assign hit       = (key_q == target);

  // key memory port, one address shared by read, write and clearing
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[pos_r] <= key_wdata;
    end
    key_q <= key_mem[pos_r];
  end

  // record memory port
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[pos_r] <= rec_r;
    end
    rec_q <= rec_mem[pos_r];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    key_nxt       = key_r;
    rec_nxt       = rec_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_slot_nxt  = out_slot_r;
    out_rec_nxt   = out_rec_r;
    out_st_nxt    = out_st_r;
    key_we        = 1'b0;
    key_wdata     = '0;
    rec_we        = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        key_we = 1'b1;
        if (pos_r == LAST_SLOT) begin
          pos_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_phone_number == '0) begin
            // zero key marks empty slots, reject it
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_slot_nxt  = '0;
            out_rec_nxt   = '0;
            out_st_nxt    = ST_INVALID;
          end else begin
            cmd_nxt   = in_command;
            key_nxt   = in_phone_number;
            rec_nxt   = in_record_handle;
            shift_nxt = in_phone_number;
            pos_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        // fold until the value fits the slot width, then one compare-subtract
        if (fold_done) begin
          pos_nxt   = mod_step;
          state_nxt = S_READ;
        end else begin
          shift_nxt = fold_sum;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_slot_nxt  = pos_r;
          out_st_nxt    = ST_OK;
          state_nxt     = S_IDLE;
          if (is_insert) begin
            key_we      = 1'b1;
            key_wdata   = key_r;
            rec_we      = 1'b1;
            out_rec_nxt = rec_r;
          end else begin
            out_rec_nxt = rec_q;
            if (cmd_r == CMD_DELETE) begin
              key_we    = 1'b1;
              key_wdata = '0;
            end
          end
        end else if (cnt_r == LAST_PROBE) begin
          // probe sequence exhausted
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_slot_nxt  = '0;
          out_rec_nxt   = '0;
          out_st_nxt    = is_insert ? ST_FULL : ST_NOT_FOUND;
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          pos_nxt   = pos_inc;
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    shift_r     <= shift_nxt;
    key_r       <= key_nxt;
    rec_r       <= rec_nxt;
    cmd_r       <= cmd_nxt;
    out_found_r <= out_found_nxt;
    out_slot_r  <= out_slot_nxt;
    out_rec_r   <= out_rec_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_slot_index = out_slot_r;
  assign out_record_out = out_rec_r;
  assign out_status     = out_st_r;

  // checks
  `LPHT_ASSERT_SAME(a_beat_when_idle, out_valid, !busy, "result beat while busy")
  `LPHT_ASSERT_NEXT(a_zero_key_rejected, start && !busy && (in_phone_number == '0),
    out_valid && (out_status == ST_INVALID), "zero key not rejected next cycle")
  `LPHT_ASSERT_SAME(a_found_is_ok, out_valid && out_found, out_status == ST_OK,
    "found beat with error status")
  `LPHT_ASSERT_SAME(a_pos_in_table, state_r == S_READ || state_r == S_CMP,
    pos_r <= LAST_SLOT, "probe position beyond table")
  `LPHT_ASSERT_NEXT(a_miss_ends, (state_r == S_CMP) && !hit && (cnt_r == LAST_PROBE),
    out_valid && !out_found, "exhausted probe without miss beat")

endmodule

@@ tb/sv/linear_probe_hash_table_top_tb.sv @@
// self-checking testbench for the linear probe hash table: directed, table-full and random beats
// depends on lpht_pkg and linear_probe_hash_table_top
`timescale 1ns / 1ps

module linear_probe_hash_table_top_tb;
  import lpht_pkg::*;

  localparam int TABLE_SLOTS = DEF_TABLE_SLOTS;
  localparam int MAX_PROBES  = DEF_MAX_PROBES;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam longint unsigned KEY_MAX = (64'd1 << KEY_W) - 1;
  // the unused command code falls back to a lookup
  localparam logic [CMD_W-1:0] CMD_ALIAS_SEARCH = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int LIVE_CAP    = 450;
  localparam longint CYCLE_LIMIT = 25_000_000;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [REC_W-1:0] rec;
  } table_cmd_t;

  typedef struct {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [REC_W-1:0]  rec;
    logic [ST_W-1:0]   status;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_command = '0;
  logic [KEY_W-1:0]  in_phone_number = '0;
  logic [REC_W-1:0]  in_record_handle = '0;
  logic              out_valid;
  logic              out_found;
  logic [SLOT_W-1:0] out_slot_index;
  logic [REC_W-1:0]  out_record_out;
  logic [ST_W-1:0]   out_status;

  // shadow copy of the table contents
  bit [KEY_W-1:0] shadow_key [TABLE_SLOTS];
  bit [REC_W-1:0] shadow_rec [TABLE_SLOTS];

  table_cmd_t     pending_cmds[$];
  table_result_t  expected_results[$];
  logic [KEY_W-1:0] live_keys[$];
  table_result_t  oldest;
  table_cmd_t     next_cmd;
  int             send_idle_pct = 36;
  int             mismatch_count = 0;
  longint         cycle_count = 0;

  linear_probe_hash_table_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_phone_number  (in_phone_number),
    .in_record_handle (in_record_handle),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_slot_index   (out_slot_index),
    .out_record_out   (out_record_out),
    .out_status       (out_status)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first slot of the probe run holding target, -1 when none
  function automatic int probe_slot(logic [KEY_W-1:0] key, logic [KEY_W-1:0] target);
    int pos;
    pos = int'(key % TABLE_SLOTS);
    for (int i = 0; i <= MAX_PROBES; i++) begin
      if (shadow_key[pos] == target) return pos;
      pos = (pos == TABLE_SLOTS - 1) ? 0 : pos + 1;
    end
    return -1;
  endfunction

  // apply one command to the shadow table and queue its result
  function automatic void predict_table_op(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                           logic [REC_W-1:0] rec);
    table_result_t res;
    int s;
    res = '{1'b0, '0, '0, ST_OK};
    if (key == '0) begin
      res.status = ST_INVALID;
    end else if (cmd == CMD_INSERT) begin
      s = probe_slot(key, '0);
      if (s < 0) begin
        res.status = ST_FULL;
      end else begin
        shadow_key[s] = key;
        shadow_rec[s] = rec;
        res = '{1'b1, SLOT_W'(s), rec, ST_OK};
      end
    end else begin
      s = probe_slot(key, key);
      if (s < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        res = '{1'b1, SLOT_W'(s), shadow_rec[s], ST_OK};
        if (cmd == CMD_DELETE) shadow_key[s] = '0;
      end
    end
    expected_results.push_back(res);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[KEY_W-1:0];
  endfunction

  // random key whose home slot is the given one
  function automatic logic [KEY_W-1:0] key_with_home(int home);
    longint unsigned v;
    v = longint'(random_key());
    v = v - (v % TABLE_SLOTS) + home;
    if (v > KEY_MAX) v = v - TABLE_SLOTS;
    if (v == 0) v = TABLE_SLOTS;
    return v[KEY_W-1:0];
  endfunction

  function automatic void push_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [REC_W-1:0] rec);
    pending_cmds.push_back('{cmd, key, rec});
  endfunction

  // key for a new insert: clustered near the wrap point, small, or anywhere
  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(9))
      0, 1, 2: k = key_with_home((985 + $urandom_range(23)) % TABLE_SLOTS);
      3:       k = KEY_W'($urandom_range(1, 4000));
      default: k = random_key();
    endcase
    if (k == '0) k = 1;
    return k;
  endfunction

  // mostly hits on live keys and inserts, some misses, zero keys and the spare code
  task automatic gen_random(int count);
    int op;
    int idx;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      op = $urandom_range(99);
      if (op < 40 && live_keys.size() >= LIVE_CAP) op = 70;
      if (op >= 40 && op < 80 && live_keys.size() == 0) op = 0;
      if (op < 40) begin
        if (live_keys.size() != 0 && $urandom_range(9) == 0)
          k = live_keys[$urandom_range(live_keys.size() - 1)];
        else
          k = fresh_key();
        live_keys.push_back(k);
        push_cmd(CMD_INSERT, k, REC_W'($urandom()));
      end else if (op < 65) begin
        push_cmd(CMD_SEARCH, live_keys[$urandom_range(live_keys.size() - 1)], REC_W'($urandom()));
      end else if (op < 80) begin
        idx = $urandom_range(live_keys.size() - 1);
        push_cmd(CMD_DELETE, live_keys[idx], REC_W'($urandom()));
        live_keys.delete(idx);
      end else if (op < 87) begin
        push_cmd(CMD_SEARCH, fresh_key(), REC_W'($urandom()));
      end else if (op < 90) begin
        push_cmd(CMD_DELETE, fresh_key(), REC_W'($urandom()));
      end else if (op < 93) begin
        push_cmd(CMD_W'($urandom_range(3)), '0, REC_W'($urandom()));
      end else begin
        if (live_keys.size() != 0 && $urandom_range(1) == 0)
          k = live_keys[$urandom_range(live_keys.size() - 1)];
        else
          k = fresh_key();
        push_cmd(CMD_ALIAS_SEARCH, k, REC_W'($urandom()));
      end
    end
  endtask

  // sampled between edges so the driver's updates have settled
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // driver: present queued beats, idle at random, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) predict_table_op(in_command, in_phone_number, in_record_handle);
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = pending_cmds.pop_front();
        start            <= 1'b1;
        in_command       <= next_cmd.cmd;
        in_phone_number  <= next_cmd.key;
        in_record_handle <= next_cmd.rec;
      end else begin
        start            <= 1'b0;
        in_command       <= CMD_W'($urandom_range(3));
        in_phone_number  <= random_key();
        in_record_handle <= REC_W'($urandom());
      end
    end
  end

  // monitor: every result beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: found=%0d slot=%0d rec=%h status=%0d",
                   out_found, out_slot_index, out_record_out, out_status);
        mismatch_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_found !== oldest.found || out_slot_index !== oldest.slot ||
            out_record_out !== oldest.rec || out_status !== oldest.status) begin
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch: exp found=%0d slot=%0d rec=%h status=%0d, got %0d %0d %h %0d",
                     oldest.found, oldest.slot, oldest.rec, oldest.status,
                     out_found, out_slot_index, out_record_out, out_status);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[linear_probe_hash_table_top] ERROR");
      $finish;
    end
  end

  initial begin
    longint unsigned top;
    logic [KEY_W-1:0] k_lo;
    logic [KEY_W-1:0] k_hi;
    logic [KEY_W-1:0] k_ones;
    logic [KEY_W-1:0] k_fill;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero keys, misses on an empty table, wrap, duplicates, spare code
    top    = KEY_MAX - (KEY_MAX % TABLE_SLOTS) + (TABLE_SLOTS - 1);
    if (top > KEY_MAX) top = top - TABLE_SLOTS;
    k_hi   = top[KEY_W-1:0];
    k_lo   = KEY_W'(TABLE_SLOTS - 1);
    k_ones = '1;
    send_idle_pct = 36;
    push_cmd(CMD_SEARCH, '0, 16'hFFFF);
    push_cmd(CMD_INSERT, '0, 16'h1234);
    push_cmd(CMD_DELETE, '0, 16'h0000);
    push_cmd(CMD_ALIAS_SEARCH, '0, 16'h5555);
    push_cmd(CMD_SEARCH, KEY_W'(1), 16'h0000);
    push_cmd(CMD_INSERT, k_lo, 16'hFFFF);
    push_cmd(CMD_INSERT, k_hi, 16'hAAAA);
    push_cmd(CMD_INSERT, k_ones, 16'h0000);
    push_cmd(CMD_INSERT, k_lo, 16'h5555);
    push_cmd(CMD_SEARCH, k_hi, 16'h0000);
    push_cmd(CMD_DELETE, k_lo, 16'h0000);
    // search must walk past the slot just emptied
    push_cmd(CMD_SEARCH, k_hi, 16'h0000);
    push_cmd(CMD_SEARCH, k_lo, 16'h0000);
    push_cmd(CMD_ALIAS_SEARCH, k_ones, 16'hFFFF);
    push_cmd(CMD_DELETE, k_hi, 16'h0000);
    push_cmd(CMD_DELETE, k_lo, 16'h0000);
    push_cmd(CMD_DELETE, k_lo, 16'h0000);
    push_cmd(CMD_DELETE, k_ones, 16'h0000);
    push_cmd(CMD_SEARCH, KEY_W'(64'd999999999999999), 16'h0000);
    wait_drained();

    // random traffic; the sender pauses for a full drain between chunks
    send_idle_pct = 36;
    gen_random(300);
    wait_drained();
    send_idle_pct = 51;
    gen_random(300);
    wait_drained();
    send_idle_pct = 0;
    gen_random(250);
    wait_drained();

    // fill every empty slot from its own home, then overflow the full table
    k_fill = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (shadow_key[i] == '0) begin
        k_fill = key_with_home(i);
        push_cmd(CMD_INSERT, k_fill, REC_W'($urandom()));
      end
    end
    push_cmd(CMD_INSERT, fresh_key(), 16'hBEEF);
    push_cmd(CMD_SEARCH, fresh_key(), 16'h0000);
    push_cmd(CMD_SEARCH, k_fill, 16'h0000);
    push_cmd(CMD_INSERT, '0, 16'h0000);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[linear_probe_hash_table_top] OK");
    end else begin
      $display("[linear_probe_hash_table_top] ERROR");
    end
    $finish;
  end

endmodule
